### sv/fcs_pkg.sv
// Shared types and constants for the filled circle span generator.
// Used by fcs_ctrl, fcs_datapath and the top level; no dependencies.
`default_nettype none

package fcs_pkg;

    localparam int CENTER_W       = 11;
    localparam int RADIUS_W       = 7;
    localparam int COORD_W        = 13;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 8 * COORD_W;
    localparam int MAX_RADIUS_DEF = 64;
    // hard cap on span groups per circle
    localparam int MAX_GROUPS     = 64;
    localparam int GROUP_CNT_W    = $clog2(MAX_GROUPS);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;  // take a new circle word into the walk registers
        logic step;  // run one loop iteration and load the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic radius_zero;  // incoming radius is zero
        logic last;         // the group being stepped is the final one
    } t_dp_status;

endpackage : fcs_pkg

`default_nettype wire

### sv/fcs_datapath.sv
// Datapath: walk registers of the midpoint circle loop and the output register.
// Depends on fcs_pkg; driven by fcs_ctrl through t_ctrl_cmd.
`default_nettype none

module fcs_datapath #(
    parameter int MAX_RADIUS = fcs_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic [fcs_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  wire fcs_pkg::t_ctrl_cmd               i_cmd,
    output fcs_pkg::t_dp_status                   o_status,
    output logic [fcs_pkg::OUT_TDATA_W-1:0]       o_out_data,
    output logic                                  o_out_last
);
    import fcs_pkg::*;

    localparam int XW = $clog2(MAX_RADIUS + 1) + 1;
    localparam int EW = $clog2(2 * MAX_RADIUS + 1) + 3;

    typedef logic signed [COORD_W-1:0] t_coord;

    logic [CENTER_W-1:0] in_cx, in_cy;
    logic [RADIUS_W-1:0] in_r, r_sat;

    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [EW-1:0] r_sx, r_sy, r_err, r_diam;
    logic signed [EW-1:0] n_sx, n_sy, n_err, err1;
    logic [CENTER_W-1:0]  r_cx, r_cy;
    logic [GROUP_CNT_W-1:0] r_cnt;
    logic                 last;

    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;

    t_coord cx13, cy13, x13, y13;

    assign in_cx = i_in_data[CENTER_W-1:0];
    assign in_cy = i_in_data[2*CENTER_W-1:CENTER_W];
    assign in_r  = i_in_data[2*CENTER_W+RADIUS_W-1:2*CENTER_W];
    assign r_sat = (in_r > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : in_r;

    // one loop iteration: optional y move, then optional x move on updated error
    always_comb begin
        n_y  = r_y;
        n_sy = r_sy;
        err1 = r_err;
        if (r_err[EW-1] || r_err == '0) begin
            n_y  = r_y + XW'(1);
            err1 = r_err + r_sy;
            n_sy = r_sy + EW'(2);
        end
        n_x   = r_x;
        n_sx  = r_sx;
        n_err = err1;
        if (!err1[EW-1] && err1 != '0) begin
            n_x   = r_x - XW'(1);
            n_sx  = r_sx + EW'(2);
            n_err = err1 + n_sx - r_diam;
        end
    end

    assign last = (n_x < n_y) || (r_cnt == GROUP_CNT_W'(MAX_GROUPS - 1));

    assign cx13 = $signed({{(COORD_W-CENTER_W){1'b0}}, r_cx});
    assign cy13 = $signed({{(COORD_W-CENTER_W){1'b0}}, r_cy});
    assign x13  = COORD_W'(r_x);
    assign y13  = COORD_W'(r_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= in_cx;
            r_cy   <= in_cy;
            r_x    <= XW'(r_sat) - XW'(1);
            r_y    <= '0;
            r_sx   <= EW'(1);
            r_sy   <= EW'(1);
            r_diam <= EW'({r_sat, 1'b0});
            r_err  <= EW'(1) - EW'({r_sat, 1'b0});
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_err <= n_err;
            r_cnt <= r_cnt + GROUP_CNT_W'(1);
        end
        if (i_cmd.step) begin
            r_out_data <= {t_coord'(cy13 - x13), t_coord'(cy13 + x13),
                           t_coord'(cx13 + y13), t_coord'(cx13 - y13),
                           t_coord'(cy13 - y13), t_coord'(cy13 + y13),
                           t_coord'(cx13 + x13), t_coord'(cx13 - x13)};
            r_out_last <= last;
        end
    end

    assign o_status.radius_zero = (in_r == '0);
    assign o_status.last        = last;
    assign o_out_data           = r_out_data;
    assign o_out_last           = r_out_last;

endmodule : fcs_datapath

`default_nettype wire

### sv/fcs_ctrl.sv
// Controller: idle/run state machine and output valid flag.
// Depends on fcs_pkg; commands fcs_datapath through t_ctrl_cmd.
`default_nettype none

module fcs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire fcs_pkg::t_dp_status  i_status,
    output fcs_pkg::t_ctrl_cmd        o_cmd,
    output fcs_pkg::t_state           o_state
);
    import fcs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && !i_status.radius_zero) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // output slot is free or being emptied this cycle
                o_cmd.step = !r_out_valid || i_out_ready;
                if (o_cmd.step && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule : fcs_ctrl

`default_nettype wire

### sv/filled_circle_span_generator_top.sv
// Filled circle span generator: takes one circle word (center, radius) and
// emits one word of four horizontal spans per midpoint-circle iteration.
//
// Input stream s_*: one circle per word; s_tready is high only while idle.
// Output stream m_*: one span group per word, m_tlast on the last group of a
// circle. Radius zero gives no output words; radii above MAX_RADIUS saturate.
// An accepted circle is registered into the walk registers, then each group
// into the output register. Throughput: one group per cycle while m_tready
// stays high, capped at 64 groups per circle. The combinational loop update of
// x, y, error and step terms sets that rate. The output register lets the next
// circle be accepted while the last group of the previous one still waits.
// A stalled receiver holds the output word; the walk waits with it.
// Reset (synchronous, active low) returns to idle with no valid output.
`default_nettype none

module filled_circle_span_generator_top #(
    parameter int MAX_RADIUS = fcs_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // center_x[10:0], center_y[21:11], radius[28:22], zero pad[31:29]
    input  wire logic [fcs_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // wide_left, wide_right, wide_row_below, wide_row_above, narrow_left,
    // narrow_right, narrow_row_below, narrow_row_above; 13 bits each from bit 0
    output logic [fcs_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // last_group
    output logic                                    m_tlast
);
    import fcs_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_state     state;

    fcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_state     (state)
    );

    fcs_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_in_data  (s_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (m_tdata),
        .o_out_last (m_tlast)
    );

    a_zero_radius_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && status.radius_zero) |=> (state == ST_IDLE))
        else $error("zero radius circle started a walk");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && status.last) |=> (m_tvalid && m_tlast && state == ST_IDLE))
        else $error("final group did not end the walk");

    a_no_load_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == ST_RUN) |-> (!cmd.load && !s_tready))
        else $error("new circle taken during a walk");

    a_valid_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> ($past(state) == ST_RUN))
        else $error("output word appeared outside a walk");

endmodule : filled_circle_span_generator_top

`default_nettype wire
